### design/framed_byte_packet_receiver_assert.svh
// Assertion macros used by the receiver's front part.
`ifndef FRAMED_BYTE_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_BYTE_PACKET_RECEIVER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FBPR_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FBPR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fbpr_pkg.sv
// Shared types and constants of the framed byte packet receiver.
package fbpr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 9;
  // The command queue depth must be a power of two so its pointers wrap.
  localparam int QUEUE_DEPTH = 2;
  localparam int BYTE_INDEX_W = 4;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
  localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
  localparam logic [1:0] REG_END_MARKER    = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

  localparam logic [7:0] FIRST_HEADER_RST  = 8'h55;
  localparam logic [7:0] SECOND_HEADER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST    = 8'h0A;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd25;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FRAMING = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_FRAMING = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_FRAME   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] end_marker;
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_entry_t;

endpackage

### design/fbpr_ram.sv
// Generic single-port-write, registered-read RAM.
module fbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 9
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fbpr_queue.sv
// Short command queue between the front and back parts.
module fbpr_queue import fbpr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  q_entry_t wr,
  output logic     full,
  output q_entry_t rd,
  input  logic     pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.cmd   = slots[rptr];
  assign do_push  = wr.valid & ~full;
  assign do_pop   = pop & rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### design/fbpr_front.sv
// Front part: accepts bytes and ticks, tracks the frame and stores payload.
`include "framed_byte_packet_receiver_assert.svh"

module fbpr_front import fbpr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  cfg_t                                                cfg,
  input  logic                                                in_valid,
  output logic                                                in_stall,
  input  logic                                                func,
  input  logic [7:0]                                          rx_byte,
  input  logic                                                q_full,
  output q_entry_t                                            q_push,
  input  logic                                                frame_done,
  output logic                                                store_we,
  output logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] store_waddr,
  output logic [7:0]                                          store_wdata
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int FW = $clog2(PAYLOAD_BYTES + 1);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_AWAIT   = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t        phase;
  phase_t        phase_next;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [7:0]    tick;
  logic [7:0]    tick_next;
  logic [7:0]    tick_inc;
  logic          frame_pending;
  logic          frame_pending_next;
  logic          accept;
  logic          filling;
  logic          frame_open;

  assign filling    = (phase == PH_PAYLOAD) && (fill < FW'(PAYLOAD_BYTES));
  assign frame_open = (phase == PH_AWAIT) || (phase == PH_PAYLOAD);
  // A frame still being read out owns the store until its last byte is sent.
  assign in_stall   = q_full | (frame_pending & filling);
  assign accept     = in_valid & ~in_stall;
  assign tick_inc   = (tick == 8'hFF) ? tick : tick + 8'd1;

  assign store_waddr = fill[AW-1:0];
  assign store_wdata = rx_byte;

  always_comb begin
    phase_next   = phase;
    fill_next    = fill;
    tick_next    = tick;
    q_push.valid = 1'b0;
    q_push.cmd   = CMD_FRAMING;
    store_we     = 1'b0;
    if (accept) begin
      if (func) begin
        if (frame_open) begin
          tick_next = tick_inc;
          if (tick_inc >= cfg.timeout_ticks) begin
            phase_next   = PH_HUNT;
            fill_next    = '0;
            tick_next    = '0;
            q_push.valid = 1'b1;
            q_push.cmd   = CMD_TIMEOUT;
          end
        end
      end else begin
        unique case (phase)
          PH_AWAIT: begin
            if (rx_byte == cfg.second_header) begin
              phase_next = PH_PAYLOAD;
            end else begin
              phase_next   = PH_HUNT;
              fill_next    = '0;
              tick_next    = '0;
              q_push.valid = 1'b1;
              q_push.cmd   = CMD_FRAMING;
            end
          end
          PH_PAYLOAD: begin
            if (filling) begin
              store_we  = 1'b1;
              fill_next = fill + FW'(1);
            end else if (rx_byte == cfg.end_marker) begin
              phase_next   = PH_HUNT;
              fill_next    = '0;
              tick_next    = '0;
              q_push.valid = 1'b1;
              q_push.cmd   = CMD_FRAME;
            end else begin
              phase_next   = PH_HUNT;
              fill_next    = '0;
              tick_next    = '0;
              q_push.valid = 1'b1;
              q_push.cmd   = CMD_FRAMING;
            end
          end
          default: begin
            fill_next = '0;
            tick_next = '0;
            if (rx_byte == cfg.first_header) begin
              phase_next = PH_AWAIT;
            end else begin
              phase_next   = PH_HUNT;
              q_push.valid = 1'b1;
              q_push.cmd   = CMD_FRAMING;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    frame_pending_next = frame_pending;
    if (q_push.valid && (q_push.cmd == CMD_FRAME)) begin
      frame_pending_next = 1'b1;
    end else if (frame_done) begin
      frame_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      fill          <= '0;
      tick          <= '0;
      frame_pending <= 1'b0;
    end else begin
      phase         <= phase_next;
      fill          <= fill_next;
      tick          <= tick_next;
      frame_pending <= frame_pending_next;
    end
  end

  `FBPR_ASSERT_SAME(a_no_store_overwrite, clk, rst, store_we, !frame_pending,
    "payload store written while a finished frame is still being sent")
  `FBPR_ASSERT_SAME(a_frame_push_free, clk, rst,
    q_push.valid && (q_push.cmd == CMD_FRAME), !frame_pending,
    "second frame completed before the first was sent")
  `FBPR_ASSERT_SAME(a_push_has_room, clk, rst, q_push.valid, !q_full,
    "command pushed into a full queue")
  `FBPR_ASSERT_NEXT(a_fill_steps, clk, rst, store_we, fill == $past(fill) + FW'(1),
    "fill count did not advance on a payload write")

endmodule

### design/fbpr_back.sv
// Back part: turns queued commands into result transactions.
module fbpr_back import fbpr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  q_entry_t                                            q_rd,
  output logic                                                q_pop,
  output logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] store_raddr,
  input  logic [7:0]                                          store_rdata,
  output logic                                                frame_done,
  output logic                                                out_valid,
  input  logic                                                out_stall,
  output logic [1:0]                                          kind,
  output logic [7:0]                                          payload_byte,
  output logic [BYTE_INDEX_W-1:0]                             byte_index,
  output logic                                                last
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_FETCH = 3'b010,
    BK_SEND  = 3'b100
  } bk_state_t;

  bk_state_t                    state;
  bk_state_t                    state_next;
  logic [AW-1:0]                idx;
  logic [AW-1:0]                idx_next;
  logic                         out_free;
  logic                         load;
  kind_t                        load_kind;
  logic [7:0]                   load_byte;
  logic [BYTE_INDEX_W-1:0]      load_index;
  logic                         load_last;
  logic                         idx_last;
  logic [AW+BYTE_INDEX_W-1:0]   idx_wide;

  assign out_free    = ~out_valid | ~out_stall;
  assign store_raddr = idx;
  assign idx_last    = (idx == AW'(PAYLOAD_BYTES - 1));
  // Positions wrap at the width of byte_index.
  assign idx_wide    = {{BYTE_INDEX_W{1'b0}}, idx};

  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_pop      = 1'b0;
    frame_done = 1'b0;
    load       = 1'b0;
    load_kind  = KIND_FRAMING;
    load_byte  = '0;
    load_index = '0;
    load_last  = 1'b1;
    unique case (state)
      BK_FETCH: begin
        state_next = BK_SEND;
      end
      BK_SEND: begin
        if (out_free) begin
          load       = 1'b1;
          load_kind  = KIND_PAYLOAD;
          load_byte  = store_rdata;
          load_index = idx_wide[BYTE_INDEX_W-1:0];
          load_last  = idx_last;
          if (idx_last) begin
            frame_done = 1'b1;
            state_next = BK_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = BK_FETCH;
          end
        end
      end
      default: begin
        if (q_rd.valid && out_free) begin
          q_pop = 1'b1;
          case (q_rd.cmd)
            CMD_FRAME: begin
              idx_next   = '0;
              state_next = BK_FETCH;
            end
            CMD_TIMEOUT: begin
              load      = 1'b1;
              load_kind = KIND_TIMEOUT;
            end
            default: begin
              load      = 1'b1;
              load_kind = KIND_FRAMING;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= load_kind;
      payload_byte <= load_byte;
      byte_index   <= load_index;
      last         <= load_last;
    end
  end

endmodule

### design/framed_byte_packet_receiver.sv
// Top level of the framed byte packet receiver: registers and part wiring.
//
//   channel | signals                                   | direction
//   cfg     | psel penable pwrite paddr pwdata prdata   | APB write/read
//   in      | in_valid in_stall func rx_byte            | byte or tick in
//   out     | out_valid out_stall kind payload_byte ... | result out
//
// An input transaction is taken whenever in_stall is low; see below for when it rises.
// Each payload byte of a good frame takes a store read in the back part, then the
// output register load; an error or timeout report needs only the load.
// Reset is synchronous; the payload store is not cleared.
// in_stall rises while the queue is full, or while a finished frame is still being
// sent and the next byte would be written into the store.
module framed_byte_packet_receiver import fbpr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic [7:0]              rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              kind,
  output logic [7:0]              payload_byte,
  output logic [BYTE_INDEX_W-1:0] byte_index,
  output logic                    last
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  cfg_t          cfg;
  logic          cfg_write;
  q_entry_t      q_push;
  q_entry_t      q_rd;
  logic          q_full;
  logic          q_pop;
  logic          frame_done;
  logic          store_we;
  logic [AW-1:0] store_waddr;
  logic [7:0]    store_wdata;
  logic [AW-1:0] store_raddr;
  logic [7:0]    store_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_header  <= FIRST_HEADER_RST;
      cfg.second_header <= SECOND_HEADER_RST;
      cfg.end_marker    <= END_MARKER_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_FIRST_HEADER:  cfg.first_header  <= pwdata[7:0];
        REG_SECOND_HEADER: cfg.second_header <= pwdata[7:0];
        REG_END_MARKER:    cfg.end_marker    <= pwdata[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIRST_HEADER:  prdata = {24'd0, cfg.first_header};
      REG_SECOND_HEADER: prdata = {24'd0, cfg.second_header};
      REG_END_MARKER:    prdata = {24'd0, cfg.end_marker};
      REG_TIMEOUT_TICKS: prdata = {24'd0, cfg.timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  fbpr_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .rx_byte     (rx_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .frame_done  (frame_done),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata)
  );

  fbpr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .full (q_full),
    .rd   (q_rd),
    .pop  (q_pop)
  );

  fbpr_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  fbpr_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rd         (q_rd),
    .q_pop        (q_pop),
    .store_raddr  (store_raddr),
    .store_rdata  (store_rdata),
    .frame_done   (frame_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

endmodule
